// ===== hdl/smt_pkg.sv =====
// smt_pkg: shared types, codes and defaults of the subset-lattice transform block
// no dependencies; used by smt_core and subset_mobius_transform_top
`timescale 1ns / 1ps

package smt_pkg;

	// default sizes of the sample store and the stored word
	localparam int MAX_LOG_LENGTH_DEF = 10;
	localparam int SAMPLE_WIDTH_DEF   = 32;

	// fixed field widths
	localparam int VALUE_W  = 32;
	localparam int LOGLEN_W = 4;

	// register indexes (paddr[2])
	localparam logic REG_DIRECTION  = 1'b0;
	localparam logic REG_LOG_LENGTH = 1'b1;

	// register reset values
	localparam logic [LOGLEN_W-1:0] LOG_LENGTH_RESET = 4'd10;

	// direction codes
	localparam logic DIR_FORWARD = 1'b0;
	localparam logic DIR_INVERSE = 1'b1;

	// input beat kinds
	localparam logic MODE_LOAD = 1'b0;
	localparam logic MODE_READ = 1'b1;

	// result status codes
	localparam logic STATUS_VALID     = 1'b0;
	localparam logic STATUS_NOT_READY = 1'b1;

	// positions in the result tuser
	localparam int TUSER_OVERFLOW = 0;
	localparam int TUSER_STATUS   = 1;

	// host side control toward the core
	typedef struct packed {
		logic start;
		logic sub;
		logic wr_en;
		logic rd_en;
	} ctrl_t;

	// core status back to the host side
	typedef struct packed {
		logic busy;
		logic overflow;
	} stat_t;

endpackage

// ===== hdl/smt_alu.sv =====
// smt_alu: shared saturating add/subtract unit with a result register
// depends on nothing but its parameters
`timescale 1ns / 1ps

module smt_alu #(
	parameter int SAMPLE_WIDTH = 32,
	parameter int ADDR_W       = 10
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           valid_s1,
	input  logic                           sub_s1,
	input  logic signed [SAMPLE_WIDTH-1:0] cell_s1,
	input  logic signed [SAMPLE_WIDTH-1:0] partner_s1,
	input  logic        [ADDR_W-1:0]       addr_s1,
	output logic                           valid_s2,
	output logic signed [SAMPLE_WIDTH-1:0] result_s2,
	output logic                           ovf_s2,
	output logic        [ADDR_W-1:0]       addr_s2
);

	logic signed [SAMPLE_WIDTH:0]   ext_a;
	logic signed [SAMPLE_WIDTH:0]   ext_b;
	logic signed [SAMPLE_WIDTH:0]   sum;
	logic                           ovf;
	logic signed [SAMPLE_WIDTH-1:0] sat;

	// one extra bit shows overflow; clamp toward the true sign
	always_comb begin
		ext_a = {cell_s1[SAMPLE_WIDTH-1], cell_s1};
		ext_b = {partner_s1[SAMPLE_WIDTH-1], partner_s1};
		sum   = sub_s1 ? (ext_a - ext_b) : (ext_a + ext_b);
		ovf   = sum[SAMPLE_WIDTH] ^ sum[SAMPLE_WIDTH-1];
		if (ovf) begin
			sat = sum[SAMPLE_WIDTH] ? {1'b1, {(SAMPLE_WIDTH-1){1'b0}}}
			                        : {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
		end else begin
			sat = sum[SAMPLE_WIDTH-1:0];
		end
	end

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		result_s2 <= sat;
		ovf_s2    <= ovf;
		addr_s2   <= addr_s1;
	end

endmodule

// ===== hdl/smt_core.sv =====
// smt_core: sample store and the pass sequencer that drives the shared alu
// depends on smt_pkg and smt_alu
`timescale 1ns / 1ps

module smt_core #(
	parameter int MAX_LOG_LENGTH = 10,
	parameter int SAMPLE_WIDTH   = 32,
	parameter int KW             = 4
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  smt_pkg::ctrl_t                   ctrl,
	input  logic        [KW-1:0]             k_eff,
	input  logic        [MAX_LOG_LENGTH-1:0] wr_addr,
	input  logic signed [SAMPLE_WIDTH-1:0]   wr_data,
	input  logic        [MAX_LOG_LENGTH-1:0] rd_addr,
	output logic signed [SAMPLE_WIDTH-1:0]   rdata,
	output smt_pkg::stat_t                   stat
);

	localparam int AW    = MAX_LOG_LENGTH;
	localparam int CW    = MAX_LOG_LENGTH + 1;
	localparam int DEPTH = 1 << MAX_LOG_LENGTH;

	typedef enum logic [1:0] {
		C_IDLE,
		C_RUN,
		C_DRAIN
	} core_state_t;

	core_state_t state_q;
	logic [KW-1:0] pass_q;
	logic [KW-1:0] k_q;
	logic [AW-1:0] bit_q;
	logic [AW-1:0] idx_q;
	logic [AW-1:0] nmask_q;
	logic          sub_q;
	logic          ovf_q;
	logic          valid_s1;

	logic signed [SAMPLE_WIDTH-1:0] mem [DEPTH];
	logic signed [SAMPLE_WIDTH-1:0] cell_s1;
	logic signed [SAMPLE_WIDTH-1:0] partner_s1;
	logic        [AW-1:0]           addr_s1;

	logic                           valid_s2;
	logic signed [SAMPLE_WIDTH-1:0] result_s2;
	logic                           ovf_s2;
	logic        [AW-1:0]           addr_s2;

	logic                           issue;
	logic                           rd_a_en;
	logic        [AW-1:0]           rd_a_addr;
	logic                           mem_we;
	logic        [AW-1:0]           mem_waddr;
	logic signed [SAMPLE_WIDTH-1:0] mem_wdata;
	logic        [AW-1:0]           nmask;

	// store port selection: the sequencer owns the ports while running
	always_comb begin
		issue     = (state_q == C_RUN);
		rd_a_en   = issue || ctrl.rd_en;
		rd_a_addr = issue ? idx_q : rd_addr;
		mem_we    = valid_s2 || ctrl.wr_en;
		mem_waddr = valid_s2 ? addr_s2 : wr_addr;
		mem_wdata = valid_s2 ? result_s2 : wr_data;
		nmask     = AW'((CW'(1) << k_eff) - CW'(1));
	end

	// sample store: one write port, two registered read ports
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (rd_a_en) begin
			cell_s1 <= mem[rd_a_addr];
		end
		if (issue) begin
			partner_s1 <= mem[idx_q ^ bit_q];
			addr_s1    <= idx_q;
		end
	end

	// shared saturating unit
	smt_alu #(
		.SAMPLE_WIDTH(SAMPLE_WIDTH),
		.ADDR_W      (AW)
	) u_alu (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s1  (valid_s1),
		.sub_s1    (sub_q),
		.cell_s1   (cell_s1),
		.partner_s1(partner_s1),
		.addr_s1   (addr_s1),
		.valid_s2  (valid_s2),
		.result_s2 (result_s2),
		.ovf_s2    (ovf_s2),
		.addr_s2   (addr_s2)
	);

	// pass sequencer: walk indices with the pass bit set, drain after each pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= C_IDLE;
			pass_q   <= '0;
			k_q      <= '0;
			bit_q    <= '0;
			idx_q    <= '0;
			nmask_q  <= '0;
			sub_q    <= 1'b0;
			ovf_q    <= 1'b0;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= issue;
			if (valid_s2 && ovf_s2) begin
				ovf_q <= 1'b1;
			end
			unique case (state_q)
				C_IDLE: begin
					if (ctrl.start) begin
						ovf_q   <= 1'b0;
						sub_q   <= ctrl.sub;
						k_q     <= k_eff;
						nmask_q <= nmask;
						pass_q  <= '0;
						bit_q   <= AW'(1);
						idx_q   <= AW'(1);
						if (k_eff != '0) begin
							state_q <= C_RUN;
						end
					end
				end
				C_RUN: begin
					if (idx_q == nmask_q) begin
						state_q <= C_DRAIN;
					end else begin
						idx_q <= (idx_q + AW'(1)) | bit_q;
					end
				end
				C_DRAIN: begin
					if (!valid_s1 && !valid_s2) begin
						if (pass_q == KW'(k_q - KW'(1))) begin
							state_q <= C_IDLE;
						end else begin
							pass_q  <= pass_q + KW'(1);
							bit_q   <= bit_q << 1;
							idx_q   <= bit_q << 1;
							state_q <= C_RUN;
						end
					end
				end
				default: begin
					state_q <= C_IDLE;
				end
			endcase
		end
	end

	assign rdata         = cell_s1;
	assign stat.busy     = (state_q != C_IDLE);
	assign stat.overflow = ovf_q;

endmodule

// ===== hdl/subset_mobius_transform_top.sv =====
// subset_mobius_transform_top: stream and register front end of the transform block
// depends on smt_pkg and smt_core (which holds smt_alu)
//
// channel   dir  handshake         contents
// apb       in   psel/penable      direction at 0x0, log_length at 0x4
// s_*       in   s_tvalid/s_tready tdata sample, tuser mode
// m_*       out  m_tvalid/m_tready tdata value, tlast last, tuser {status, overflow}
//
// a load beat writes the store; a read beat of a not-ready set goes to the output
// register at once, else through the registered store read, then the output register
// the load beat that completes a set of 2^k starts the transform: k passes of
// 2^(k-1) store reads each and an alu pipeline drain per pass; s_tready is low
// during the transform or a read beat's store read, and while a result waits in the output
// register without m_tready; reset clears counters, flags and registers, not the store
`timescale 1ns / 1ps

module subset_mobius_transform_top #(
	parameter int MAX_LOG_LENGTH = smt_pkg::MAX_LOG_LENGTH_DEF,
	parameter int SAMPLE_WIDTH   = smt_pkg::SAMPLE_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // [31:0] sample
	input  logic [0:0]  s_tuser,  // [0] mode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,  // [31:0] value
	output logic        m_tlast,
	output logic [1:0]  m_tuser   // [0] overflow, [1] status
);

	localparam int AW      = MAX_LOG_LENGTH;
	localparam int CW      = MAX_LOG_LENGTH + 1;
	localparam int KW      = $clog2(MAX_LOG_LENGTH + 1);
	localparam int VALUE_W = smt_pkg::VALUE_W;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_XFORM,
		ST_RDATA
	} top_state_t;

	top_state_t state_q;
	logic                          direction_q;
	logic [smt_pkg::LOGLEN_W-1:0]  log_length_q;
	logic [AW-1:0]                 load_q;
	logic [AW-1:0]                 read_q;
	logic                          reading_q;
	logic                          m_tvalid_q;
	logic [VALUE_W-1:0]            m_tdata_q;
	logic                          m_tlast_q;
	logic                          m_ovf_q;
	logic                          m_status_q;

	logic                           accept;
	logic                           is_load;
	logic                           is_read;
	logic                           cfg_wr;
	logic                           out_free;
	logic [KW-1:0]                  k_eff;
	logic [AW-1:0]                  n_mask;
	logic [AW-1:0]                  load_idx;
	logic signed [VALUE_W-1:0]      sample_in;
	logic signed [SAMPLE_WIDTH-1:0] sample_sat;
	logic signed [SAMPLE_WIDTH-1:0] rdata;
	smt_pkg::ctrl_t                 ctrl;
	smt_pkg::stat_t                 stat;

	// set size: oversized lengths act as the largest one
	always_comb begin
		k_eff  = (int'(log_length_q) > MAX_LOG_LENGTH) ? KW'(MAX_LOG_LENGTH)
		                                               : KW'(log_length_q);
		n_mask = AW'((CW'(1) << k_eff) - CW'(1));
	end

	// clamp the incoming sample to the stored width
	assign sample_in = signed'(s_tdata);

	if (SAMPLE_WIDTH >= VALUE_W) begin : g_wide
		assign sample_sat = SAMPLE_WIDTH'(sample_in);
	end else begin : g_narrow
		localparam logic signed [VALUE_W-1:0] SMAX =
			VALUE_W'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1);
		localparam logic signed [VALUE_W-1:0] SMIN = ~SMAX;
		assign sample_sat = (sample_in > SMAX) ? SAMPLE_WIDTH'(SMAX) :
		                    (sample_in < SMIN) ? SAMPLE_WIDTH'(SMIN) :
		                                         SAMPLE_WIDTH'(sample_in);
	end

	// beat decode and core requests
	always_comb begin
		out_free   = !m_tvalid_q || m_tready;
		s_tready   = (state_q == ST_IDLE) && out_free;
		accept     = s_tvalid && s_tready;
		is_load    = accept && (s_tuser[0] == smt_pkg::MODE_LOAD);
		is_read    = accept && (s_tuser[0] == smt_pkg::MODE_READ);
		load_idx   = reading_q ? '0 : load_q;
		cfg_wr     = psel && penable && pwrite && pready;
		ctrl.wr_en = is_load;
		ctrl.start = is_load && (load_idx == n_mask);
		ctrl.sub   = (direction_q == smt_pkg::DIR_FORWARD);
		ctrl.rd_en = is_read && reading_q;
	end

	smt_core #(
		.MAX_LOG_LENGTH(MAX_LOG_LENGTH),
		.SAMPLE_WIDTH  (SAMPLE_WIDTH),
		.KW            (KW)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.k_eff  (k_eff),
		.wr_addr(load_idx),
		.wr_data(sample_sat),
		.rd_addr(read_q),
		.rdata  (rdata),
		.stat   (stat)
	);

	// register read-back
	assign pready = 1'b1;
	always_comb begin
		unique case (paddr[2])
			smt_pkg::REG_DIRECTION:  prdata = 32'(direction_q);
			smt_pkg::REG_LOG_LENGTH: prdata = 32'(log_length_q);
			default:                 prdata = '0;
		endcase
	end

	// control state, registers and the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			direction_q  <= smt_pkg::DIR_FORWARD;
			log_length_q <= smt_pkg::LOG_LENGTH_RESET;
			load_q       <= '0;
			read_q       <= '0;
			reading_q    <= 1'b0;
			m_tvalid_q   <= 1'b0;
			m_tdata_q    <= '0;
			m_tlast_q    <= 1'b0;
			m_ovf_q      <= 1'b0;
			m_status_q   <= smt_pkg::STATUS_VALID;
		end else begin
			// register writes; a new length restarts loading
			if (cfg_wr) begin
				unique case (paddr[2])
					smt_pkg::REG_DIRECTION: begin
						direction_q <= pwdata[0];
					end
					smt_pkg::REG_LOG_LENGTH: begin
						log_length_q <= pwdata[smt_pkg::LOGLEN_W-1:0];
						load_q       <= '0;
						read_q       <= '0;
						reading_q    <= 1'b0;
					end
					default: begin
					end
				endcase
			end

			if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (is_load) begin
						reading_q <= 1'b0;
						read_q    <= '0;
						if (ctrl.start) begin
							load_q  <= '0;
							state_q <= ST_XFORM;
						end else begin
							load_q <= load_idx + AW'(1);
						end
					end
					if (is_read) begin
						if (reading_q) begin
							state_q <= ST_RDATA;
						end else begin
							m_tvalid_q <= 1'b1;
							m_tdata_q  <= '0;
							m_tlast_q  <= 1'b0;
							m_ovf_q    <= stat.overflow;
							m_status_q <= smt_pkg::STATUS_NOT_READY;
						end
					end
				end
				ST_XFORM: begin
					if (!stat.busy) begin
						reading_q <= 1'b1;
						read_q    <= '0;
						state_q   <= ST_IDLE;
					end
				end
				ST_RDATA: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= VALUE_W'(rdata);
						m_tlast_q  <= (read_q == n_mask);
						m_ovf_q    <= stat.overflow;
						m_status_q <= smt_pkg::STATUS_VALID;
						state_q    <= ST_IDLE;
						if (read_q == n_mask) begin
							read_q    <= '0;
							load_q    <= '0;
							reading_q <= 1'b0;
						end else begin
							read_q <= read_q + AW'(1);
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid                       = m_tvalid_q;
	assign m_tdata                        = m_tdata_q;
	assign m_tlast                        = m_tlast_q;
	assign m_tuser[smt_pkg::TUSER_OVERFLOW] = m_ovf_q;
	assign m_tuser[smt_pkg::TUSER_STATUS]   = m_status_q;

`ifndef SYNTH
	// no input beat is taken while the transform owns the store
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		stat.busy |-> !s_tready)
		else $error("input accepted during transform");

	// a host write to the store never collides with a transform
	a_load_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.wr_en |-> !stat.busy)
		else $error("sample load while transform runs");

	// a not-ready result carries a zero value and no last mark
	a_not_ready_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tuser[smt_pkg::TUSER_STATUS] == smt_pkg::STATUS_NOT_READY))
		|-> (m_tdata == '0) && !m_tlast)
		else $error("not-ready result with data");

	// the end of a transform opens the read-out
	a_done_reads: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(stat.busy) |=> reading_q)
		else $error("transform end did not enter read-out");
`endif

endmodule
